@@ sv/hpq_pkg.sv @@
// hpq_pkg: shared types, codes and the sequencer microprogram for the binary heap queue.
// No dependencies; imported by every module of the block.

package hpq_pkg;

	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	localparam logic [0:0] REG_ORDER = 1'b0;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [3:0] step_t;

	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_DISP    = 4'd1;
	localparam step_t S_INS     = 4'd2;
	localparam step_t S_UP_RD   = 4'd3;
	localparam step_t S_UP_CMP  = 4'd4;
	localparam step_t S_UP_MOVE = 4'd5;
	localparam step_t S_PLACE   = 4'd6;
	localparam step_t S_REM     = 4'd7;
	localparam step_t S_LOADL   = 4'd8;
	localparam step_t S_DN_RD   = 4'd9;
	localparam step_t S_DN_CMP  = 4'd10;
	localparam step_t S_DN_MOVE = 4'd11;
	localparam step_t S_ERRF    = 4'd12;
	localparam step_t S_ERRE    = 4'd13;
	localparam step_t S_SPARE   = 4'd14;
	localparam step_t S_EMIT    = 4'd15;

	typedef enum logic [3:0] {
		A_NONE,
		A_ACCEPT,
		A_INS_INIT,
		A_RD_PARENT,
		A_MOVE_UP,
		A_PLACE,
		A_REM_INIT,
		A_LOAD_LAST,
		A_RD_CHILD,
		A_MOVE_DN,
		A_ST_FULL,
		A_ST_EMPTY,
		A_EMIT
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_IS_REM,
		C_FULL,
		C_EMPTY,
		C_POS_ZERO,
		C_NOT_UP,
		C_NO_CHILD,
		C_NOT_DN,
		C_OUT_BUSY
	} cond_t;

	// guard: action is suppressed when the jump is taken
	typedef struct packed {
		act_t  act;
		logic  guard;
		cond_t cond;
		step_t target;
	} cw_t;

	typedef struct packed {
		logic is_rem;
		logic full;
		logic empty;
		logic pos_zero;
		logic up_beats;
		logic no_child;
		logic dn_beats;
		logic out_busy;
	} flags_t;

	function automatic logic beats(input logic order, input data_t a, input data_t b);
		return order ? (a > b) : (a < b);
	endfunction

	// Microprogram; the step after S_EMIT wraps to S_IDLE.
	function automatic cw_t ucode(input step_t pc);
		cw_t w;
		w = '{act: A_NONE, guard: 1'b0, cond: C_ALWAYS, target: S_IDLE};
		case (pc)
			S_IDLE:    w = '{act: A_ACCEPT,    guard: 1'b1, cond: C_NO_REQ,   target: S_IDLE};
			S_DISP:    w = '{act: A_NONE,      guard: 1'b0, cond: C_IS_REM,   target: S_REM};
			S_INS:     w = '{act: A_INS_INIT,  guard: 1'b1, cond: C_FULL,     target: S_ERRF};
			S_UP_RD:   w = '{act: A_RD_PARENT, guard: 1'b1, cond: C_POS_ZERO, target: S_PLACE};
			S_UP_CMP:  w = '{act: A_NONE,      guard: 1'b0, cond: C_NOT_UP,   target: S_PLACE};
			S_UP_MOVE: w = '{act: A_MOVE_UP,   guard: 1'b0, cond: C_ALWAYS,   target: S_UP_RD};
			S_PLACE:   w = '{act: A_PLACE,     guard: 1'b0, cond: C_ALWAYS,   target: S_EMIT};
			S_REM:     w = '{act: A_REM_INIT,  guard: 1'b1, cond: C_EMPTY,    target: S_ERRE};
			S_LOADL:   w = '{act: A_LOAD_LAST, guard: 1'b0, cond: C_NEVER,    target: S_IDLE};
			S_DN_RD:   w = '{act: A_RD_CHILD,  guard: 1'b1, cond: C_NO_CHILD, target: S_PLACE};
			S_DN_CMP:  w = '{act: A_NONE,      guard: 1'b0, cond: C_NOT_DN,   target: S_PLACE};
			S_DN_MOVE: w = '{act: A_MOVE_DN,   guard: 1'b0, cond: C_ALWAYS,   target: S_DN_RD};
			S_ERRF:    w = '{act: A_ST_FULL,   guard: 1'b0, cond: C_ALWAYS,   target: S_EMIT};
			S_ERRE:    w = '{act: A_ST_EMPTY,  guard: 1'b0, cond: C_ALWAYS,   target: S_EMIT};
			S_SPARE:   w = '{act: A_NONE,      guard: 1'b0, cond: C_ALWAYS,   target: S_IDLE};
			S_EMIT:    w = '{act: A_EMIT,      guard: 1'b1, cond: C_OUT_BUSY, target: S_EMIT};
			default:   w = '{act: A_NONE,      guard: 1'b0, cond: C_ALWAYS,   target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/hpq_seq.sv @@
// hpq_seq: step counter, microprogram lookup and jump logic.
// Depends on hpq_pkg; drives the action code into hpq_dpath.

module hpq_seq
	import hpq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  flags_t flags,
	output act_t   act
);

	step_t pc_q;
	cw_t   cw;
	logic  jump;

	assign cw = ucode(pc_q);

	always_comb begin
		case (cw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_REQ:   jump = !in_valid;
			C_IS_REM:   jump = flags.is_rem;
			C_FULL:     jump = flags.full;
			C_EMPTY:    jump = flags.empty;
			C_POS_ZERO: jump = flags.pos_zero;
			C_NOT_UP:   jump = !flags.up_beats;
			C_NO_CHILD: jump = flags.no_child;
			C_NOT_DN:   jump = !flags.dn_beats;
			C_OUT_BUSY: jump = flags.out_busy;
			default:    jump = 1'b0;
		endcase
	end

	assign act      = (cw.guard && jump) ? A_NONE : cw.act;
	assign in_stall = (pc_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= jump ? cw.target : step_t'(pc_q + 1'b1);
		end
	end

endmodule

@@ sv/hpq_dpath.sv @@
// hpq_dpath: heap memory, sift registers, comparators and the result register.
// Depends on hpq_pkg; driven by action codes from hpq_seq.

module hpq_dpath
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               order_mode,
	input  act_t               act,
	output flags_t             flags,
	input  logic               mode,
	input  data_t              value,
	input  logic               out_stall,
	output logic               out_valid,
	output data_t              top_value,
	output logic [COUNT_W-1:0] count,
	output logic               is_empty,
	output logic [1:0]         status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	data_t mem [CAPACITY];

	logic [CW-1:0]      n_q;
	logic [AW-1:0]      pos_q;
	data_t              cur_q;
	data_t              root_q;
	data_t              rd0_q;
	data_t              rd1_q;
	logic               mode_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	data_t              top_q;
	logic [COUNT_W-1:0] count_q;
	logic               empty_q;
	logic [1:0]         ostat_q;

	logic [AW-1:0] parent;
	logic [IW-1:0] lc_w;
	logic [IW-1:0] rc_w;
	logic          take_right;
	data_t         best;
	logic [AW-1:0] best_idx;

	logic          we;
	logic [AW-1:0] waddr;
	data_t         wdata;
	logic          re0;
	logic          re1;
	logic [AW-1:0] ra0;
	logic [AW-1:0] ra1;

	assign parent     = (pos_q - 1'b1) >> 1;
	assign lc_w       = IW'({pos_q, 1'b1});
	assign rc_w       = lc_w + 1'b1;
	assign take_right = (rc_w < IW'(n_q)) && beats(order_mode, rd1_q, rd0_q);
	assign best       = take_right ? rd1_q : rd0_q;
	assign best_idx   = take_right ? AW'(rc_w) : AW'(lc_w);

	assign flags.is_rem   = (mode_q == MODE_REMOVE);
	assign flags.full     = (n_q == CW'(CAPACITY));
	assign flags.empty    = (n_q == '0);
	assign flags.pos_zero = (pos_q == '0);
	assign flags.up_beats = beats(order_mode, cur_q, rd0_q);
	assign flags.no_child = (lc_w >= IW'(n_q));
	assign flags.dn_beats = beats(order_mode, best, cur_q);
	assign flags.out_busy = out_valid_q && out_stall;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		re0   = 1'b0;
		re1   = 1'b0;
		ra0   = parent;
		ra1   = AW'(rc_w);
		case (act)
			A_MOVE_UP: begin
				we    = 1'b1;
				wdata = rd0_q;
			end
			A_PLACE: begin
				we = 1'b1;
			end
			A_MOVE_DN: begin
				we    = 1'b1;
				wdata = best;
			end
			A_RD_PARENT: begin
				re0 = 1'b1;
			end
			A_REM_INIT: begin
				re0 = 1'b1;
				ra0 = AW'(n_q - 1'b1);
			end
			A_RD_CHILD: begin
				re0 = 1'b1;
				re1 = 1'b1;
				ra0 = AW'(lc_w);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re0) begin
			rd0_q <= mem[ra0];
		end
		if (re1) begin
			rd1_q <= mem[ra1];
		end
	end

	// root copy follows every write to entry 0
	always_ff @(posedge clk) begin
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
		case (act)
			A_ACCEPT: begin
				mode_q   <= mode;
				cur_q    <= value;
				status_q <= ST_OK;
			end
			A_INS_INIT: begin
				pos_q <= AW'(n_q);
			end
			A_MOVE_UP: begin
				pos_q <= parent;
			end
			A_REM_INIT: begin
				pos_q <= '0;
			end
			A_LOAD_LAST: begin
				cur_q <= rd0_q;
			end
			A_MOVE_DN: begin
				pos_q <= best_idx;
			end
			A_ST_FULL: begin
				status_q <= ST_FULL;
			end
			A_ST_EMPTY: begin
				status_q <= ST_EMPTY;
			end
			A_EMIT: begin
				top_q   <= (n_q != '0) ? root_q : '0;
				count_q <= COUNT_W'(n_q);
				empty_q <= (n_q == '0);
				ostat_q <= status_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (act)
				A_INS_INIT: n_q <= n_q + 1'b1;
				A_REM_INIT: n_q <= n_q - 1'b1;
				default:    n_q <= n_q;
			endcase
			if (act == A_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign count     = count_q;
	assign is_empty  = empty_q;
	assign status    = ostat_q;

endmodule

@@ sv/binary_heap_priority_queue_top.sv @@
// Binary heap priority queue of signed 32-bit values, CAPACITY entries, min or max order.
// Every request (insert or remove top) gives one result: top value, count, empty flag and
// status. One request is worked at a time; the next may be taken while the last result
// waits at the output. An insert sifts the new value up and a remove sifts the last entry
// down from the root; an insert on a full heap or a remove on an empty one only sets the
// status. Each sift level is a registered memory read, a compare and a write, three
// microprogram steps.
// order_mode lives at byte address 0 of the APB port.
// Depends on hpq_pkg, hpq_seq, hpq_dpath.

module binary_heap_priority_queue_top
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  data_t              value,
	output logic               out_valid,
	input  logic               out_stall,
	output data_t              top_value,
	output logic [COUNT_W-1:0] count,
	output logic               is_empty,
	output logic [1:0]         status
);

	logic   order_q;
	logic   reg_hit;
	flags_t flags;
	act_t   act;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_ORDER);
	assign prdata  = reg_hit ? PDATA_W'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			order_q <= pwdata[0];
		end
	end

	hpq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.act      (act)
	);

	hpq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.order_mode (order_q),
		.act        (act),
		.flags      (flags),
		.mode       (mode),
		.value      (value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.top_value  (top_value),
		.count      (count),
		.is_empty   (is_empty),
		.status     (status)
	);

endmodule

@@ sv/hpq_checker.sv @@
// hpq_checker: port-level assertions on the heap queue result channel, bound to the top level.
// Depends on hpq_pkg and binary_heap_priority_queue_top.

module hpq_checker
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input data_t              top_value,
	input logic [COUNT_W-1:0] count,
	input logic               is_empty,
	input logic [1:0]         status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(top_value) && $stable(count))
		else $error("stalled result changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0)
		else $error("empty heap shows nonzero top");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> count == COUNT_W'(CAPACITY))
		else $error("full status without full count");

	a_rem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> is_empty)
		else $error("remove-on-empty status with entries held");

endmodule

bind binary_heap_priority_queue_top hpq_checker #(
	.CAPACITY (CAPACITY)
) u_hpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.top_value (top_value),
	.count     (count),
	.is_empty  (is_empty),
	.status    (status)
);
